// ===== rtl/utf8_stream_decoder_unit_assert.svh =====
// assertion macros shared by the utf8 stream decoder rtl
// no dependencies; take in with include inside a module body
`ifndef UTF8_STREAM_DECODER_UNIT_ASSERT_SVH
`define UTF8_STREAM_DECODER_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define U8SD_ASSERT_IMP(name, clk_s, rstn_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define U8SD_ASSERT_NXT(name, clk_s, rstn_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/utf8sd_pkg.sv =====
// types, codes and constants of the utf8 stream decoder
// no dependencies; imported by every module of the block
`default_nettype none

package utf8sd_pkg;

  localparam int CP_W        = 21;
  localparam int LEN_W       = 3;
  localparam int ST_W        = 3;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_PAD_W   = OUT_TDATA_W - CP_W - LEN_W - ST_W;
  localparam int CFG_AW      = 3;
  localparam int CFG_DW      = 32;

  // register index, taken from the word address
  localparam logic REG_CHECK_RANGES = 1'b0;

  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_VAL  = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_VAL  = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_VAL  = 8'hF0;
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_VAL   = 8'h80;

  localparam logic [CP_W-1:0] SURR_LO = 21'h00D800;
  localparam logic [CP_W-1:0] SURR_HI = 21'h00DFFF;
  localparam logic [CP_W-1:0] CP_MAX  = 21'h10FFFF;

  typedef enum logic [ST_W-1:0] {
    ST_OK            = 3'd0,
    ST_BAD_LEAD      = 3'd1,
    ST_BAD_CONT      = 3'd2,
    ST_SURROGATE     = 3'd3,
    ST_ABOVE_MAX     = 3'd4,
    ST_TRUNCATED     = 3'd5,
    ST_END_AFTER_ERR = 3'd6
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_string;
  } in_word_t;

  typedef struct packed {
    logic             string_done;
    status_t          status;
    logic [LEN_W-1:0] seq_length;
    logic [CP_W-1:0]  code_point;
  } res_t;

  typedef struct packed {
    logic [1:0]       bytes_left;
    logic [CP_W-1:0]  partial_value;
    logic [LEN_W-1:0] sequence_size;
    logic             skipping;
  } seq_state_t;

endpackage

`default_nettype wire

// ===== rtl/utf8sd_cfg.sv =====
// configuration register bank, apb-style write and read
// depends on utf8sd_pkg
`default_nettype none

module utf8sd_cfg
  import utf8sd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   check_ranges
);

  logic check_ranges_r;
  logic check_ranges_nxt;
  logic wr_en;

  // pready is tied high, so the access phase always completes
  assign wr_en = psel && penable && pwrite;

  always_comb begin
    check_ranges_nxt = check_ranges_r;
    if (wr_en && (paddr[CFG_AW-1] == REG_CHECK_RANGES)) begin
      check_ranges_nxt = pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      check_ranges_r <= 1'b1;
    end else begin
      check_ranges_r <= check_ranges_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[CFG_AW-1] == REG_CHECK_RANGES) begin
      prdata[0] = check_ranges_r;
    end
  end

  assign check_ranges = check_ranges_r;

endmodule

`default_nettype wire

// ===== rtl/utf8sd_in_reg.sv =====
// input register: holds one byte word ahead of the decode logic
// depends on utf8sd_pkg
`default_nettype none

module utf8sd_in_reg
  import utf8sd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_word_t in_word,
  input  wire logic     advance,
  output logic          held_valid,
  output in_word_t      held_word
);

  logic     valid_r;
  logic     valid_nxt;
  in_word_t word_r;
  logic     load;

  assign in_ready = !valid_r || advance;
  assign load     = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word_r <= in_word;
    end
  end

  assign held_valid = valid_r;
  assign held_word  = word_r;

endmodule

`default_nettype wire

// ===== rtl/utf8sd_core.sv =====
// sequence state and single-pass decode of one byte
// depends on utf8sd_pkg
`default_nettype none

module utf8sd_core
  import utf8sd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     advance,
  input  wire in_word_t word,
  input  wire logic     check_ranges,
  output logic          has_res,
  output res_t          res,
  output logic          idle
);

  seq_state_t st_r;
  seq_state_t st_nxt;

  logic [7:0]      b;
  logic            eos;
  logic [CP_W-1:0] acc_pv;
  logic [1:0]      bl_dec;
  logic            fail;
  status_t         fail_code;

  assign b      = word.data_byte;
  assign eos    = word.end_of_string;
  assign acc_pv = {st_r.partial_value[CP_W-7:0], b[5:0]};
  assign bl_dec = st_r.bytes_left - 2'd1;

  always_comb begin
    st_nxt    = st_r;
    has_res   = 1'b0;
    res       = '0;
    fail      = 1'b0;
    fail_code = ST_OK;
    if (st_r.skipping) begin
      if (eos) begin
        st_nxt          = '0;
        has_res         = 1'b1;
        res.status      = ST_END_AFTER_ERR;
        res.string_done = 1'b1;
      end
    end else if (st_r.bytes_left == 2'd0) begin
      priority if (!b[7]) begin
        st_nxt          = '0;
        has_res         = 1'b1;
        res.code_point  = {{(CP_W-8){1'b0}}, b};
        res.seq_length  = LEN_W'(1);
        res.string_done = eos;
      end else if ((b & LEAD2_MASK) == LEAD2_VAL) begin
        st_nxt.partial_value = {{(CP_W-5){1'b0}}, b[4:0]};
        st_nxt.sequence_size = LEN_W'(2);
        st_nxt.bytes_left    = 2'd1;
        fail                 = eos;
        fail_code            = ST_TRUNCATED;
      end else if ((b & LEAD3_MASK) == LEAD3_VAL) begin
        st_nxt.partial_value = {{(CP_W-4){1'b0}}, b[3:0]};
        st_nxt.sequence_size = LEN_W'(3);
        st_nxt.bytes_left    = 2'd2;
        fail                 = eos;
        fail_code            = ST_TRUNCATED;
      end else if ((b & LEAD4_MASK) == LEAD4_VAL) begin
        st_nxt.partial_value = {{(CP_W-3){1'b0}}, b[2:0]};
        st_nxt.sequence_size = LEN_W'(4);
        st_nxt.bytes_left    = 2'd3;
        fail                 = eos;
        fail_code            = ST_TRUNCATED;
      end else begin
        fail      = 1'b1;
        fail_code = ST_BAD_LEAD;
      end
    end else if ((b & CONT_MASK) != CONT_VAL) begin
      fail      = 1'b1;
      fail_code = ST_BAD_CONT;
    end else if (bl_dec != 2'd0) begin
      st_nxt.partial_value = acc_pv;
      st_nxt.bytes_left    = bl_dec;
      fail                 = eos;
      fail_code            = ST_TRUNCATED;
    end else begin
      // last continuation byte: range checks when check_ranges is set, then emit
      priority if (check_ranges && (acc_pv >= SURR_LO) && (acc_pv <= SURR_HI)) begin
        fail      = 1'b1;
        fail_code = ST_SURROGATE;
      end else if (check_ranges && (acc_pv > CP_MAX)) begin
        fail      = 1'b1;
        fail_code = ST_ABOVE_MAX;
      end else begin
        st_nxt          = '0;
        has_res         = 1'b1;
        res.code_point  = acc_pv;
        res.seq_length  = st_r.sequence_size;
        res.string_done = eos;
      end
    end
    if (fail) begin
      st_nxt          = '0;
      st_nxt.skipping = !eos;
      has_res         = 1'b1;
      res             = '0;
      res.status      = fail_code;
      res.string_done = eos;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  assign idle = (st_r.bytes_left == 2'd0) && !st_r.skipping;

endmodule

`default_nettype wire

// ===== rtl/utf8sd_out_reg.sv =====
// result register between the decode logic and the output channel
// depends on utf8sd_pkg
`default_nettype none

module utf8sd_out_reg
  import utf8sd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic load,
  input  wire res_t res_in,
  output logic      free,
  output logic      out_valid,
  input  wire logic out_ready,
  output res_t      res_out
);

  logic valid_r;
  logic valid_nxt;
  res_t res_r;

  assign free = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign out_valid = valid_r;
  assign res_out   = res_r;

endmodule

`default_nettype wire

// ===== rtl/utf8_stream_decoder_unit.sv =====
// channel  | dir | handshake           | payload
// in_      | in  | tvalid / tready     | tdata = data_byte, tlast = end_of_string
// out_     | out | tvalid / tready     | tdata = code_point, seq_length, status; tlast
// cfg_     | in  | psel/penable/pwrite | paddr, pwdata, prdata (check_ranges at 0x0)
//
// one byte word per cycle while the output does not stall; a taken word is held in the
// input register, then decoded, and any result it gives goes into the result register
// the decode is one pass of logic on the input register and sequence state
// reset: synchronous, active low; check_ranges comes out of reset as 1
// an output stall holds the result register, and the input register then fills;
// in_tready drops only while both are occupied
// depends on utf8sd_pkg, utf8sd_cfg, utf8sd_in_reg, utf8sd_core, utf8sd_out_reg
`default_nettype none

module utf8_stream_decoder_unit
  import utf8sd_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // [7:0] data_byte
  input  wire logic                   in_tlast,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic      [OUT_TDATA_W-1:0] out_tdata,  // [20:0] code_point, [23:21] seq_length,
                                                  // [26:24] status, [31:27] zero
  output logic                        out_tlast,
  input  wire logic                   cfg_psel,
  input  wire logic                   cfg_penable,
  input  wire logic                   cfg_pwrite,
  input  wire logic [CFG_AW-1:0]      cfg_paddr,
  input  wire logic [CFG_DW-1:0]      cfg_pwdata,
  output logic      [CFG_DW-1:0]      cfg_prdata,
  output logic                        cfg_pready
);

  in_word_t in_word;
  in_word_t held_word;
  logic     held_valid;
  logic     advance;
  logic     check_ranges;
  logic     has_res;
  res_t     res_nxt;
  res_t     res_q;
  logic     out_free;
  logic     core_idle;

  assign cfg_pready            = 1'b1;
  assign in_word.data_byte     = in_tdata;
  assign in_word.end_of_string = in_tlast;

  // a held word moves on only when the result register can take its result
  assign advance = held_valid && out_free;

  utf8sd_cfg u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (cfg_psel),
    .penable      (cfg_penable),
    .pwrite       (cfg_pwrite),
    .paddr        (cfg_paddr),
    .pwdata       (cfg_pwdata),
    .prdata       (cfg_prdata),
    .check_ranges (check_ranges)
  );

  utf8sd_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_word    (in_word),
    .advance    (advance),
    .held_valid (held_valid),
    .held_word  (held_word)
  );

  utf8sd_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .advance      (advance),
    .word         (held_word),
    .check_ranges (check_ranges),
    .has_res      (has_res),
    .res          (res_nxt),
    .idle         (core_idle)
  );

  utf8sd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance && has_res),
    .res_in    (res_nxt),
    .free      (out_free),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .res_out   (res_q)
  );

  assign out_tdata = {{OUT_PAD_W{1'b0}}, res_q.status, res_q.seq_length, res_q.code_point};
  assign out_tlast = res_q.string_done;

`include "utf8_stream_decoder_unit_assert.svh"

  `U8SD_ASSERT_IMP(a_err_zero, clk, rst_n, out_tvalid && (res_q.status != ST_OK), (res_q.code_point == '0) && (res_q.seq_length == '0), "error word carries a code point or length")
  `U8SD_ASSERT_IMP(a_ok_len, clk, rst_n, out_tvalid && (res_q.status == ST_OK), (res_q.seq_length != '0) && (res_q.seq_length <= LEN_W'(4)), "ok word with bad sequence length")
  `U8SD_ASSERT_IMP(a_end_done, clk, rst_n, out_tvalid && ((res_q.status == ST_TRUNCATED) || (res_q.status == ST_END_AFTER_ERR)), res_q.string_done, "end-of-string status without string_done")
  `U8SD_ASSERT_NXT(a_eos_idle, clk, rst_n, advance && held_word.end_of_string, core_idle, "sequence state not cleared after final byte")

endmodule

`default_nettype wire
